/* src/lffa_pkg.sv */
// ----------------------------------------------------------------------------
// lffa_pkg
// Shared constants for the liveness-aware first-fit allocator.
// ----------------------------------------------------------------------------
package lffa_pkg;

  localparam int MaxRegionsDef = 64;
  localparam int AddrBitsDef   = 32;
  localparam int TimeBitsDef   = 16;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CLEARED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

endpackage

/* src/liveness_first_fit_allocator.sv */
// ----------------------------------------------------------------------------
// liveness_first_fit_allocator
// Places buffers at the lowest address free of live-overlapping regions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): opcode 0 clears the table, 1
//   allocates req_size_i bytes live over [live_begin_i, live_finish_i].
//   Output channel (out_valid_o / out_stall_i): one result per request.
//   Config channel (cfg_valid_i / cfg_ready_o): writes mem_limit; always ready.
// Operation:
//   The stored regions sit in a ring of cells that, while a scan runs,
//   rotates one slot per cycle past a single compare unit. An allocate runs
//   full passes of the ring until a pass leaves the candidate address
//   unchanged. A scan only runs with fewer than MAX_REGIONS regions stored,
//   so there are at most MAX_REGIONS passes. Clear and table-full requests
//   skip the scan. One request is in flight at a time.
// Reset: table empty, peak zero, mem_limit all ones. No clearing pass.
// A stalled result holds in the output register; the next request is
// accepted meanwhile and waits to deliver until the register frees.
// ----------------------------------------------------------------------------
module liveness_first_fit_allocator
  import lffa_pkg::*;
#(
  parameter int MAX_REGIONS = MaxRegionsDef,
  parameter int ADDR_BITS   = AddrBitsDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] req_size_i,
  input  logic [15:0] live_begin_i,
  input  logic [15:0] live_finish_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] start_addr_o,
  output logic [31:0] peak_addr_o,
  output logic        fits_o,
  output logic [1:0]  status_o
);

  localparam int CNTW = $clog2(MAX_REGIONS + 1);
  localparam int IDXW = $clog2(MAX_REGIONS);
  localparam int CMPW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [31:0]          limit_q;
  logic [CNTW-1:0]      count_q, count_d;
  logic [ADDR_BITS-1:0] peak_q, peak_d;
  logic [IDXW-1:0]      idx_q, idx_d;
  logic [ADDR_BITS-1:0] cur_q, cur_d;
  logic                 chg_q, chg_d;

  logic                 op_q;
  logic [ADDR_BITS-1:0] size_q;
  logic [TIME_BITS-1:0] lb_q, lf_q;

  logic                 ov_q;
  logic [31:0]          start_out_q, peak_out_q;
  logic                 fits_q;
  logic [1:0]           status_q;

  logic [ADDR_BITS-1:0] r_start [MAX_REGIONS];
  logic [ADDR_BITS-1:0] r_size  [MAX_REGIONS];
  logic [TIME_BITS-1:0] r_lb    [MAX_REGIONS];
  logic [TIME_BITS-1:0] r_lf    [MAX_REGIONS];

  logic shift, record, can_load, full;
  logic [ADDR_BITS:0]   rend, cend;
  logic                 move;
  logic [ADDR_BITS-1:0] fin_peak;
  logic [1:0]           fin_status;
  logic [ADDR_BITS-1:0] fin_start;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign can_load    = !ov_q || !out_stall_i;
  assign full        = (count_q == CNTW'(MAX_REGIONS));
  assign shift       = (state_q == S_SCAN);

  // compare unit at the head of the ring
  assign rend = {1'b0, r_start[0]} + {1'b0, r_size[0]};
  assign cend = {1'b0, cur_q} + {1'b0, size_q};
  assign move = (CNTW'(idx_q) < count_q) &&
                (r_lb[0] <= lf_q) && (lb_q <= r_lf[0]) &&
                (rend > {1'b0, cur_q}) && (cend > {1'b0, r_start[0]});

  assign record = (state_q == S_FIN) && can_load && (op_q == OP_ALLOC) &&
                  !full && !cend[ADDR_BITS];

  genvar g;
  generate
    for (g = 0; g < MAX_REGIONS; g++) begin : g_ring
      lffa_cell #(.ADDR_BITS(ADDR_BITS), .TIME_BITS(TIME_BITS)) u_cell (
        .clk_i      (clk_i),
        .shift_i    (shift),
        .load_i     (record && (count_q == CNTW'(g))),
        .nb_start_i (r_start[(g + 1) % MAX_REGIONS]),
        .nb_size_i  (r_size[(g + 1) % MAX_REGIONS]),
        .nb_lb_i    (r_lb[(g + 1) % MAX_REGIONS]),
        .nb_lf_i    (r_lf[(g + 1) % MAX_REGIONS]),
        .ld_start_i (cur_q),
        .ld_size_i  (size_q),
        .ld_lb_i    (lb_q),
        .ld_lf_i    (lf_q),
        .start_o    (r_start[g]),
        .size_o     (r_size[g]),
        .lb_o       (r_lb[g]),
        .lf_o       (r_lf[g])
      );
    end
  endgenerate

  always_comb begin
    fin_peak   = peak_q;
    fin_start  = '0;
    fin_status = ST_OK;
    if (op_q == OP_CLEAR) begin
      fin_peak   = '0;
      fin_status = ST_CLEARED;
    end else if (full) begin
      fin_status = ST_FULL;
    end else if (cend[ADDR_BITS]) begin
      fin_status = ST_OVERFLOW;
    end else begin
      fin_start = cur_q;
      if (cend[ADDR_BITS-1:0] > peak_q) fin_peak = cend[ADDR_BITS-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    peak_d  = peak_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    chg_d   = chg_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          cur_d = '0;
          chg_d = 1'b0;
          state_d = (opcode_i == OP_ALLOC && !full) ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (move) begin
          cur_d = rend[ADDR_BITS-1:0];
        end
        if (idx_q == IDXW'(MAX_REGIONS - 1)) begin
          idx_d = '0;
          chg_d = 1'b0;
          // a pass with no move means the candidate is final
          if (!(chg_q || move)) state_d = S_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
          chg_d = chg_q || move;
        end
      end
      S_FIN: begin
        if (can_load) begin
          peak_d  = fin_peak;
          state_d = S_IDLE;
          if (op_q == OP_CLEAR) count_d = '0;
          else if (record) count_d = count_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= '1;
      count_q <= '0;
      peak_q  <= '0;
      idx_q   <= '0;
      chg_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      idx_q   <= idx_d;
      chg_q   <= chg_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (state_q == S_FIN && can_load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (state_q == S_IDLE && in_valid_i) begin
      op_q   <= opcode_i;
      size_q <= ADDR_BITS'(req_size_i);
      lb_q   <= TIME_BITS'(live_begin_i);
      lf_q   <= TIME_BITS'(live_finish_i);
    end
    if (state_q == S_FIN && can_load) begin
      start_out_q <= 32'(fin_start);
      peak_out_q  <= 32'(fin_peak);
      fits_q      <= (CMPW'(fin_peak) < CMPW'(limit_q));
      status_q    <= fin_status;
    end
  end

  assign out_valid_o  = ov_q;
  assign start_addr_o = start_out_q;
  assign peak_addr_o  = peak_out_q;
  assign fits_o       = fits_q;
  assign status_o     = status_q;

endmodule

/* src/lffa_cell.sv */
// ----------------------------------------------------------------------------
// lffa_cell
// One region slot of the rotating region ring: shifts from its neighbor
// while a scan runs, or loads a new region.
// ----------------------------------------------------------------------------
module lffa_cell
  import lffa_pkg::*;
#(
  parameter int ADDR_BITS = AddrBitsDef,
  parameter int TIME_BITS = TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic                 load_i,
  input  logic [ADDR_BITS-1:0] nb_start_i,
  input  logic [ADDR_BITS-1:0] nb_size_i,
  input  logic [TIME_BITS-1:0] nb_lb_i,
  input  logic [TIME_BITS-1:0] nb_lf_i,
  input  logic [ADDR_BITS-1:0] ld_start_i,
  input  logic [ADDR_BITS-1:0] ld_size_i,
  input  logic [TIME_BITS-1:0] ld_lb_i,
  input  logic [TIME_BITS-1:0] ld_lf_i,
  output logic [ADDR_BITS-1:0] start_o,
  output logic [ADDR_BITS-1:0] size_o,
  output logic [TIME_BITS-1:0] lb_o,
  output logic [TIME_BITS-1:0] lf_o
);

  logic [ADDR_BITS-1:0] start_q, size_q;
  logic [TIME_BITS-1:0] lb_q, lf_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      start_q <= ld_start_i;
      size_q  <= ld_size_i;
      lb_q    <= ld_lb_i;
      lf_q    <= ld_lf_i;
    end else if (shift_i) begin
      start_q <= nb_start_i;
      size_q  <= nb_size_i;
      lb_q    <= nb_lb_i;
      lf_q    <= nb_lf_i;
    end
  end

  assign start_o = start_q;
  assign size_o  = size_q;
  assign lb_o    = lb_q;
  assign lf_o    = lf_q;

endmodule

/* src/lffa_checker.sv */
// ----------------------------------------------------------------------------
// lffa_checker
// Port-level checks on the allocator's result channel.
// ----------------------------------------------------------------------------
module lffa_checker
  import lffa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] start_addr_o,
  input logic [31:0] peak_addr_o,
  input logic [1:0]  status_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(start_addr_o) && $stable(status_o))
    else $error("stalled result changed");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CLEARED |-> start_addr_o == 0 && peak_addr_o == 0)
    else $error("clear result not zero");

  a_err_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_OVERFLOW)
      |-> start_addr_o == 0)
    else $error("error result with nonzero start");

endmodule

bind liveness_first_fit_allocator lffa_checker u_lffa_checker (.*);

/* bench/liveness_first_fit_allocator_test.sv */
// ----------------------------------------------------------------------------
// liveness_first_fit_allocator_test
// Drives clear and allocate requests with random gaps and stalls, predicts
// each placement with a first-fit search over live-overlapping regions, and
// compares every result field by field.
// ----------------------------------------------------------------------------
module liveness_first_fit_allocator_test;
  import lffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRegions = 64;
  localparam logic [32:0] AddrMax = 33'hFFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        opcode_i = OP_CLEAR;
  logic [31:0] req_size_i = '0;
  logic [15:0] live_begin_i = '0;
  logic [15:0] live_finish_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] start_addr_o;
  logic [31:0] peak_addr_o;
  logic        fits_o;
  logic [1:0]  status_o;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] peak_addr;
    logic        fits;
    logic [1:0]  status;
  } placement_t;

  // predictor state
  logic [31:0] mem_limit_q;
  logic [31:0] tbl_start [NumRegions];
  logic [31:0] tbl_size [NumRegions];
  logic [15:0] tbl_begin [NumRegions];
  logic [15:0] tbl_finish [NumRegions];
  int          tbl_count;
  logic [32:0] peak_q;

  placement_t  pending_q[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          requests_sent = 0;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;

  liveness_first_fit_allocator DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $display("timeout with %0d results outstanding", pending_q.size());
    $finish;
  end

  function automatic placement_t place_request(logic op, logic [31:0] size,
                                               logic [15:0] lb, logic [15:0] lf);
    placement_t res;
    int          order[$];
    int          pos;
    logic [32:0] cur;
    logic [32:0] rend;
    cur = '0;
    if (op == OP_CLEAR) begin
      tbl_count = 0;
      peak_q = '0;
      res = '{32'd0, 32'd0, (33'd0 < {1'b0, mem_limit_q}), ST_CLEARED};
      return res;
    end
    if (tbl_count >= NumRegions) begin
      res = '{32'd0, peak_q[31:0], (peak_q < {1'b0, mem_limit_q}), ST_FULL};
      return res;
    end
    // stable insertion by start address among live-meeting regions
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_begin[i] <= lf && lb <= tbl_finish[i]) begin
        pos = order.size();
        while (pos > 0 && tbl_start[order[pos-1]] > tbl_start[i]) pos--;
        order.insert(pos, i);
      end
    end
    foreach (order[k]) begin
      rend = {1'b0, tbl_start[order[k]]} + tbl_size[order[k]];
      if (rend <= cur) continue;
      if (rend <= cur || cur + size <= {1'b0, tbl_start[order[k]]}) break;
      cur = rend;
    end
    if (cur + size > AddrMax) begin
      res = '{32'd0, peak_q[31:0], (peak_q < {1'b0, mem_limit_q}), ST_OVERFLOW};
      return res;
    end
    tbl_start[tbl_count] = cur[31:0];
    tbl_size[tbl_count] = size;
    tbl_begin[tbl_count] = lb;
    tbl_finish[tbl_count] = lf;
    tbl_count++;
    if (cur + size > peak_q) peak_q = cur + size;
    res = '{cur[31:0], peak_q[31:0], (peak_q < {1'b0, mem_limit_q}), ST_OK};
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    placement_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result start", start_addr_o, 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (start_addr_o !== want.start_addr)
          report_mismatch("start_addr", start_addr_o, want.start_addr);
        if (peak_addr_o !== want.peak_addr)
          report_mismatch("peak_addr", peak_addr_o, want.peak_addr);
        if (fits_o !== want.fits) report_mismatch("fits", fits_o, want.fits);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // valid stays high after acceptance until the next request or idle
  // phase takes over, so it is driven once per time step
  task automatic send_request(logic op, logic [31:0] size, logic [15:0] lb,
                              logic [15:0] lf);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    opcode_i <= op;
    req_size_i <= size;
    live_begin_i <= lb;
    live_finish_i <= lf;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.insert(pending_q.size(), place_request(op, size, lb, lf));
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_mem_limit(logic [31:0] value);
    wait_idle();
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    mem_limit_q = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_alloc(int span);
    logic [31:0] size;
    logic [15:0] lb;
    logic [15:0] lf;
    case ($urandom_range(9))
      0: size = $urandom();
      1: size = 32'hFFFF_FFFF - $urandom_range(3);
      2: size = 32'd0;
      default: size = $urandom_range(255);
    endcase
    lb = 16'($urandom_range(span));
    lf = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'(lb + $urandom_range(span));
    if ($urandom_range(19) == 0) lb = 16'($urandom());
    send_request(OP_ALLOC, size, lb, lf);
  endtask

  task automatic test_directed();
    send_request(OP_ALLOC, 32'd16, 16'd0, 16'd5);
    send_request(OP_ALLOC, 32'd8, 16'd3, 16'd9);       // overlaps in time
    send_request(OP_ALLOC, 32'd4, 16'd10, 16'd12);     // disjoint in time
    send_request(OP_ALLOC, 32'd0, 16'd0, 16'd20);      // zero size
    send_request(OP_ALLOC, 32'd8, 16'd9, 16'd2);       // inverted interval
    send_request(OP_ALLOC, 32'd4, 16'hFFFF, 16'hFFFF);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 16'd0, 16'hFFFF); // overflows
    send_request(OP_ALLOC, 32'hFFFF_FFE0, 16'd100, 16'd100);
    send_request(OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 16'd0, 16'd0);     // exact top
    send_request(OP_ALLOC, 32'd1, 16'd0, 16'd0);
    send_request(OP_CLEAR, 32'd0, 16'd0, 16'd0);
    send_request(OP_ALLOC, 32'd32, 16'd0, 16'd0);
    send_request(OP_ALLOC, 32'd32, 16'd1, 16'd1);            // equal starts
    send_request(OP_ALLOC, 32'd8, 16'd0, 16'd1);
  endtask

  task automatic test_table_full();
    send_request(OP_CLEAR, 32'd0, 16'd0, 16'd0);
    for (int i = 0; i < NumRegions + 2; i++)
      send_request(OP_ALLOC, 32'd2, 16'(i % 5), 16'(i % 5 + 1));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(24) == 0)
        send_request(OP_CLEAR, $urandom(), 16'($urandom()), 16'($urandom()));
      else send_random_alloc($urandom_range(1) ? 8 : 40);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles <= 3000;
    for (int i = 0; i < 6; i++) send_random_alloc(8);
  endtask

  initial begin
    mem_limit_q = 32'hFFFF_FFFF;
    tbl_count = 0;
    peak_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_mem_limit(32'd0);
    send_request(OP_CLEAR, 32'd0, 16'd0, 16'd0);
    send_request(OP_ALLOC, 32'd4, 16'd0, 16'd0);
    write_mem_limit(32'd100);
    test_table_full();
    write_mem_limit(32'd40);
    sender_idle_pct = 58;
    test_random(12);
    sender_idle_pct = 0;
    stall_pct = 58;
    write_mem_limit(32'hFFFF_FFFF);
    test_random(12);
    sender_idle_pct = 25;
    stall_pct = 25;
    write_mem_limit($urandom());
    test_random(12);
    sender_idle_pct = 0;
    stall_pct = 0;
    test_backpressure();
    test_random(12);
    wait_idle();
    $display("Covered %0d requests, %0d results: clears, table full, overflow,",
             requests_sent, results_seen);
    $display("zero sizes, inverted intervals, several memory limits and back-pressure.");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/lffa_pkg.sv
src/lffa_cell.sv
src/liveness_first_fit_allocator.sv
src/lffa_checker.sv
bench/liveness_first_fit_allocator_test.sv
